// ===== rtl/crsp_pkg.sv =====
`default_nettype none

package crsp_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] HDR_IN    = 8'hea;
  localparam logic [7:0] HDR_OUT   = 8'heb;
  localparam logic [7:0] CMD_ERR   = 8'h0d;
  localparam logic [7:0] CMD_RD_IV = 8'h01;
  localparam logic [7:0] CMD_WR_IV = 8'h02;
  localparam logic [7:0] CMD_RD_PW = 8'h03;
  localparam logic [7:0] CMD_WR_PW = 8'h04;

  localparam logic [7:0] COUNT_MAX = 8'hff;
  localparam logic [7:0] MIN_FRAME = 8'd4;

  typedef enum logic [2:0] {
    POS_HDR   = 3'd0,
    POS_CMD   = 3'd1,
    POS_SEQ   = 3'd2,
    POS_LEN   = 3'd3,
    POS_DATA0 = 3'd4,
    POS_DATA1 = 3'd5
  } rsp_pos_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       save_request;
    logic       restart_adv;
  } tx_item_t;

  typedef struct packed {
    logic [7:0] cmd;
    logic [1:0] data_len;
    logic [7:0] data0;
    logic [7:0] data1;
    logic       save;
    logic       restart;
  } rsp_desc_t;

endpackage

`default_nettype wire

// ===== rtl/crsp_front.sv =====
`default_nettype none

module crsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  input  crsp_pkg::rx_item_t  rx,
  input  logic                queue_full,
  output logic                rx_stall,
  output logic                push,
  output crsp_pkg::rsp_desc_t desc
);
  import crsp_pkg::*;

  logic [7:0]  byte_count;
  logic        frame_overflow;
  logic [7:0]  header_byte;
  logic [7:0]  command_code;
  logic [7:0]  sequence_byte;
  logic [7:0]  declared_length;
  logic [7:0]  data0;
  logic [7:0]  data1;
  logic [15:0] interval_setting;
  logic [7:0]  power_setting;

  logic        accept;
  logic        cap_ok;
  logic [7:0]  total;
  logic [7:0]  hdr_e;
  logic [7:0]  cmd_e;
  logic [7:0]  seq_e;
  logic [7:0]  len_e;
  logic [7:0]  d0_e;
  logic [7:0]  d1_e;
  logic        frame_bad;
  logic        respond;
  logic        set_iv;
  logic        set_pw;

  assign rx_stall = queue_full;
  assign accept   = rx_valid && !rx_stall;
  assign cap_ok   = !frame_overflow && (byte_count != COUNT_MAX);
  assign total    = cap_ok ? byte_count + 8'd1 : byte_count;

  assign hdr_e = (cap_ok && byte_count == 8'(POS_HDR))   ? rx.rx_byte : header_byte;
  assign cmd_e = (cap_ok && byte_count == 8'(POS_CMD))   ? rx.rx_byte : command_code;
  assign seq_e = (cap_ok && byte_count == 8'(POS_SEQ))   ? rx.rx_byte : sequence_byte;
  assign len_e = (cap_ok && byte_count == 8'(POS_LEN))   ? rx.rx_byte : declared_length;
  assign d0_e  = (cap_ok && byte_count == 8'(POS_DATA0)) ? rx.rx_byte : data0;
  assign d1_e  = (cap_ok && byte_count == 8'(POS_DATA1)) ? rx.rx_byte : data1;

  assign frame_bad = !cap_ok || (total < MIN_FRAME) || (hdr_e != HDR_IN) ||
                     (({1'b0, len_e} + 9'd4) != {1'b0, total});

  always_comb begin
    desc         = '0;
    desc.cmd     = CMD_ERR;
    respond      = 1'b1;
    set_iv       = 1'b0;
    set_pw       = 1'b0;
    if (!frame_bad) begin
      unique case (cmd_e)
        CMD_RD_IV: begin
          if (total == MIN_FRAME && seq_e == 8'd0 && len_e == 8'd0) begin
            desc.cmd      = CMD_RD_IV;
            desc.data_len = 2'd2;
            desc.data0    = interval_setting[15:8];
            desc.data1    = interval_setting[7:0];
          end
        end
        CMD_WR_IV: begin
          if (len_e == 8'd2) begin
            desc.cmd     = CMD_WR_IV;
            desc.save    = 1'b1;
            desc.restart = 1'b1;
            set_iv       = 1'b1;
          end
        end
        CMD_RD_PW: begin
          if (total == MIN_FRAME && seq_e == 8'd0 && len_e == 8'd0) begin
            desc.cmd      = CMD_RD_PW;
            desc.data_len = 2'd1;
            desc.data0    = power_setting;
          end
        end
        CMD_WR_PW: begin
          if (len_e == 8'd1) begin
            desc.cmd  = CMD_WR_PW;
            desc.save = 1'b1;
            set_pw    = 1'b1;
          end
        end
        default: begin
          respond = 1'b0;
        end
      endcase
    end
  end

  assign push = accept && rx.rx_last && respond;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      frame_overflow   <= 1'b0;
      header_byte      <= '0;
      command_code     <= '0;
      sequence_byte    <= '0;
      declared_length  <= '0;
      data0            <= '0;
      data1            <= '0;
      interval_setting <= '0;
      power_setting    <= '0;
    end else if (accept) begin
      header_byte     <= hdr_e;
      command_code    <= cmd_e;
      sequence_byte   <= seq_e;
      declared_length <= len_e;
      data0           <= d0_e;
      data1           <= d1_e;
      if (rx.rx_last) begin
        byte_count     <= '0;
        frame_overflow <= 1'b0;
        if (set_iv) begin
          interval_setting <= {d0_e, d1_e};
        end
        if (set_pw) begin
          power_setting <= d0_e;
        end
      end else if (cap_ok) begin
        byte_count <= total;
      end else begin
        frame_overflow <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crsp_fifo.sv =====
`default_nettype none

module crsp_fifo #(
  parameter int Depth = crsp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crsp_pkg::rsp_desc_t push_desc,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output crsp_pkg::rsp_desc_t head
);
  import crsp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rsp_desc_t       entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crsp_back.sv =====
`default_nettype none

module crsp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  crsp_pkg::rsp_desc_t head,
  output logic                pop,
  output logic                tx_valid,
  input  logic                tx_stall,
  output crsp_pkg::tx_item_t  tx
);
  import crsp_pkg::*;

  logic [2:0] idx;
  logic [2:0] last_idx;
  logic       load;
  logic       is_last;
  tx_item_t   item_next;

  assign last_idx = 3'(POS_LEN) + {1'b0, head.data_len};
  assign is_last  = (idx == last_idx);
  assign load     = head_valid && (!tx_valid || !tx_stall);
  assign pop      = load && is_last;

  always_comb begin
    item_next              = '0;
    item_next.tx_last      = is_last;
    item_next.save_request = head.save;
    item_next.restart_adv  = head.restart;
    unique case (idx)
      3'(POS_HDR):   item_next.tx_byte = HDR_OUT;
      3'(POS_CMD):   item_next.tx_byte = head.cmd;
      3'(POS_SEQ):   item_next.tx_byte = 8'd0;
      3'(POS_LEN):   item_next.tx_byte = {6'd0, head.data_len};
      3'(POS_DATA0): item_next.tx_byte = head.data0;
      3'(POS_DATA1): item_next.tx_byte = head.data1;
      default:       item_next.tx_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        tx_valid <= 1'b1;
        idx      <= is_last ? '0 : idx + 3'd1;
      end else if (!tx_stall) begin
        tx_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= 3'(POS_DATA1))
    else $error("Response byte index ran past the longest response.");

  a_mid_frame_head: assert property (@(posedge clk) disable iff (rst)
    idx != '0 |-> head_valid)
    else $error("Response descriptor left the queue before its last byte.");

  a_header_first: assert property (@(posedge clk) disable iff (rst)
    load && idx == '0 |=> tx_valid && tx.tx_byte == HDR_OUT)
    else $error("Response did not open with the response header.");
`endif

endmodule

`default_nettype wire

// ===== rtl/command_frame_responder_top.sv =====
`default_nettype none

// Command frame responder.
// The rx channel takes one command frame byte per transfer, with rx_last on
// the final byte. A frame is header 0xea, command, sequence, data length and
// the data. On the final byte the frame is checked and a response frame that
// starts with 0xeb is queued: a read of the advertising interval or transmit
// power, a set acknowledgment, or an error frame. Well-formed frames with an
// unknown command give none. The tx channel carries one response byte per
// transfer, with tx_last on its final byte; save_request is held on every byte
// of a successful set response and restart_adv on those of an interval set.
// Throughput: one rx transfer per cycle while the queue is not full. A response
// goes through the queue and then the output register; one response byte leaves
// per cycle while tx is not stalled, four to six per frame; the response
// serializer sets the sustained rate when frames are shorter than their responses.
// When the tx side stalls, the output register holds its byte; the response
// queue fills and rx_stall rises only while the queue is full.
// Reset clears the frame counter, the queue and the stored settings to zero.

module command_frame_responder_top #(
  parameter int QueueDepth = crsp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  crsp_pkg::rx_item_t rx,
  output logic               tx_valid,
  input  logic               tx_stall,
  output crsp_pkg::tx_item_t tx
);
  import crsp_pkg::*;

  logic      push;
  logic      pop;
  logic      queue_full;
  logic      head_valid;
  rsp_desc_t push_desc;
  rsp_desc_t head;

  crsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx         (rx),
    .queue_full (queue_full),
    .rx_stall   (rx_stall),
    .push       (push),
    .desc       (push_desc)
  );

  crsp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  crsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .tx_valid   (tx_valid),
    .tx_stall   (tx_stall),
    .tx         (tx)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crsp_pkg::*;

  localparam logic [7:0] CMD_UNKNOWN    = 8'h55;
  localparam logic [7:0] CMD_UNKNOWN_LO = 8'h00;
  localparam logic [7:0] CMD_UNKNOWN_HI = 8'hff;
  localparam int RANDOM_BYTES = 80;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     rx_valid = 1'b0;
  logic     rx_stall;
  rx_item_t rx = '0;
  logic     tx_valid;
  logic     tx_stall = 1'b0;
  tx_item_t tx;

  command_frame_responder_top dut (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx       (rx),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx       (tx)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Predictor state, mirroring the frame capture and the two settings.
  logic [7:0]  frame_cnt = '0;
  logic        frame_ovf = 1'b0;
  logic [7:0]  cap_hdr = '0;
  logic [7:0]  cap_cmd = '0;
  logic [7:0]  cap_seq = '0;
  logic [7:0]  cap_len = '0;
  logic [7:0]  cap_data0 = '0;
  logic [7:0]  cap_data1 = '0;
  logic [15:0] exp_interval = '0;
  logic [7:0]  exp_power = '0;

  tx_item_t   response_bytes[$];
  logic [7:0] frame_buf[$];
  int         mismatches = 0;
  int         sent_bytes = 0;
  int         burst_left = 0;
  tx_item_t   want;

  task automatic queue_response(input logic [7:0] cmd, input int n, input logic [7:0] d0,
                                input logic [7:0] d1, input logic save, input logic restart);
    logic [7:0] bytes[6];
    int         len;
    bytes[0] = HDR_OUT;
    bytes[1] = cmd;
    bytes[2] = 8'h00;
    bytes[3] = 8'(n);
    bytes[4] = d0;
    bytes[5] = d1;
    len = 4 + n;
    for (int i = 0; i < len; i++) begin
      response_bytes.push_back('{bytes[i], i == len - 1, save, restart});
    end
  endtask

  task automatic predict_rx_byte(input logic [7:0] b, input logic last);
    logic [8:0] total;
    logic       too_long;
    if (frame_ovf || frame_cnt == COUNT_MAX) begin
      frame_ovf = 1'b1;
    end else begin
      if (frame_cnt < 8'd6) begin
        case (rsp_pos_t'(frame_cnt[2:0]))
          POS_HDR:   cap_hdr = b;
          POS_CMD:   cap_cmd = b;
          POS_SEQ:   cap_seq = b;
          POS_LEN:   cap_len = b;
          POS_DATA0: cap_data0 = b;
          POS_DATA1: cap_data1 = b;
          default: ;
        endcase
      end
      frame_cnt = frame_cnt + 8'd1;
    end
    if (!last) return;
    too_long = frame_ovf;
    total = {1'b0, frame_cnt};
    frame_cnt = '0;
    frame_ovf = 1'b0;
    if (too_long || total < {1'b0, MIN_FRAME} || cap_hdr != HDR_IN ||
        {1'b0, cap_len} + 9'd4 != total) begin
      queue_response(CMD_ERR, 0, 8'h00, 8'h00, 1'b0, 1'b0);
      return;
    end
    case (cap_cmd)
      CMD_RD_IV: begin
        if (cap_seq != 8'h00 || cap_len != 8'h00)
          queue_response(CMD_ERR, 0, 8'h00, 8'h00, 1'b0, 1'b0);
        else
          queue_response(CMD_RD_IV, 2, exp_interval[15:8], exp_interval[7:0], 1'b0, 1'b0);
      end
      CMD_WR_IV: begin
        if (cap_len != 8'd2) begin
          queue_response(CMD_ERR, 0, 8'h00, 8'h00, 1'b0, 1'b0);
        end else begin
          exp_interval = {cap_data0, cap_data1};
          queue_response(CMD_WR_IV, 0, 8'h00, 8'h00, 1'b1, 1'b1);
        end
      end
      CMD_RD_PW: begin
        if (cap_seq != 8'h00 || cap_len != 8'h00)
          queue_response(CMD_ERR, 0, 8'h00, 8'h00, 1'b0, 1'b0);
        else
          queue_response(CMD_RD_PW, 1, exp_power, 8'h00, 1'b0, 1'b0);
      end
      CMD_WR_PW: begin
        if (cap_len != 8'd1) begin
          queue_response(CMD_ERR, 0, 8'h00, 8'h00, 1'b0, 1'b0);
        end else begin
          exp_power = cap_data0;
          queue_response(CMD_WR_PW, 0, 8'h00, 8'h00, 1'b1, 1'b0);
        end
      end
      default: ;
    endcase
  endtask

  // The sender works in bursts; a gap of zero lets bursts run back to back.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    rx_valid <= 1'b1;
    rx <= '{b, last};
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    burst_left--;
    sent_bytes++;
    predict_rx_byte(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic start_frame(input logic [7:0] hdr, input logic [7:0] cmd,
                             input logic [7:0] seq, input logic [7:0] len);
    frame_buf.delete();
    frame_buf.push_back(hdr);
    frame_buf.push_back(cmd);
    frame_buf.push_back(seq);
    frame_buf.push_back(len);
  endtask

  task automatic send_header_frame(input logic [7:0] hdr, input logic [7:0] cmd,
                                   input logic [7:0] seq, input logic [7:0] len,
                                   input int ndata);
    start_frame(hdr, cmd, seq, len);
    repeat (ndata) frame_buf.push_back(8'($urandom_range(0, 255)));
    send_frame();
  endtask

  task automatic test_reads_after_reset();
    send_header_frame(HDR_IN, CMD_RD_IV, 8'h00, 8'd0, 0);
    send_header_frame(HDR_IN, CMD_RD_PW, 8'h00, 8'd0, 0);
  endtask

  task automatic test_settings_extremes();
    start_frame(HDR_IN, CMD_WR_IV, 8'hff, 8'd2);
    frame_buf.push_back(8'hff);
    frame_buf.push_back(8'hff);
    send_frame();
    send_header_frame(HDR_IN, CMD_RD_IV, 8'h00, 8'd0, 0);
    start_frame(HDR_IN, CMD_WR_PW, 8'h00, 8'd1);
    frame_buf.push_back(8'hff);
    send_frame();
    send_header_frame(HDR_IN, CMD_RD_PW, 8'h00, 8'd0, 0);
    start_frame(HDR_IN, CMD_WR_IV, 8'h00, 8'd2);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    send_frame();
    start_frame(HDR_IN, CMD_WR_PW, 8'h00, 8'd1);
    frame_buf.push_back(8'h00);
    send_frame();
    send_header_frame(HDR_IN, CMD_RD_IV, 8'h00, 8'd0, 0);
    send_header_frame(HDR_IN, CMD_RD_PW, 8'h00, 8'd0, 0);
  endtask

  task automatic test_frame_errors();
    send_header_frame(HDR_OUT, CMD_RD_IV, 8'h00, 8'd0, 0);
    send_header_frame(HDR_IN, CMD_RD_PW, 8'h00, 8'd3, 1);
    send_header_frame(HDR_IN, CMD_RD_IV, 8'h01, 8'd0, 0);
    send_header_frame(HDR_IN, CMD_RD_PW, 8'h00, 8'd1, 1);
    send_header_frame(HDR_IN, CMD_WR_IV, 8'h00, 8'd1, 1);
    send_header_frame(HDR_IN, CMD_WR_PW, 8'h00, 8'd2, 2);
    for (int n = 1; n < 4; n++) begin
      start_frame(HDR_IN, CMD_RD_IV, 8'h00, 8'd0);
      while (frame_buf.size() > n) void'(frame_buf.pop_back());
      send_frame();
    end
    send_header_frame(HDR_IN, CMD_UNKNOWN_LO, 8'h00, 8'd0, 0);
    send_header_frame(HDR_IN, CMD_UNKNOWN_HI, 8'h00, 8'd2, 2);
    send_header_frame(HDR_IN, CMD_ERR, 8'h00, 8'd0, 0);
    send_header_frame(HDR_IN, CMD_RD_PW, 8'h00, 8'd0, 0);
  endtask

  task automatic test_long_frames();
    send_header_frame(HDR_IN, CMD_UNKNOWN, 8'h00, 8'd251, 251);
    send_header_frame(HDR_IN, CMD_WR_PW, 8'h00, 8'd1, 253);
    send_header_frame(HDR_IN, CMD_RD_IV, 8'h00, 8'd0, 0);
  endtask

  task automatic test_random_frames();
    int         target;
    logic [7:0] cmd;
    logic [7:0] seq;
    int         len;
    int         ndata;
    target = sent_bytes + RANDOM_BYTES;
    while (sent_bytes < target) begin
      case ($urandom_range(0, 3))
        0: cmd = CMD_RD_IV;
        1: cmd = CMD_WR_IV;
        2: cmd = CMD_RD_PW;
        default: cmd = CMD_WR_PW;
      endcase
      seq = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if (cmd == CMD_RD_IV || cmd == CMD_RD_PW) begin
            if ($urandom_range(0, 4) != 0) seq = 8'h00;
            len = 0;
          end else begin
            len = (cmd == CMD_WR_IV) ? 2 : 1;
          end
          send_header_frame(HDR_IN, cmd, seq, 8'(len), len);
        end
        6: begin
          len = $urandom_range(0, 4);
          ndata = ($urandom_range(0, 1) == 0) ? len : $urandom_range(0, 4);
          send_header_frame(HDR_IN, cmd, seq, 8'(len), ndata);
        end
        7: begin
          len = $urandom_range(0, 3);
          send_header_frame(HDR_IN, 8'($urandom_range(0, 255)), seq, 8'(len), len);
        end
        8: begin
          frame_buf.delete();
          repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom_range(0, 255)));
          send_frame();
        end
        default: begin
          start_frame(HDR_IN, cmd, 8'h00, 8'd0);
          ndata = $urandom_range(1, 3);
          while (frame_buf.size() > ndata) void'(frame_buf.pop_back());
          send_frame();
        end
      endcase
    end
  endtask

  // The receiver switches between random stall patterns.
  int stall_left = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: tx_stall <= 1'b0;
      1: tx_stall <= 1'($urandom_range(0, 1));
      2: tx_stall <= stall_left[2];
      default: tx_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && tx_valid && !tx_stall) begin
      if (response_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: byte %h last %b save %b restart %b",
                   tx.tx_byte, tx.tx_last, tx.save_request, tx.restart_adv);
      end else begin
        want = response_bytes.pop_front();
        if (tx.tx_byte !== want.tx_byte || tx.tx_last !== want.tx_last ||
            tx.save_request !== want.save_request || tx.restart_adv !== want.restart_adv) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %h last %b save %b restart %b, got %h %b %b %b",
                     want.tx_byte, want.tx_last, want.save_request, want.restart_adv,
                     tx.tx_byte, tx.tx_last, tx.save_request, tx.restart_adv);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reads_after_reset();
    test_settings_extremes();
    test_frame_errors();
    test_long_frames();
    test_random_frames();
    rx_valid <= 1'b0;
    while (response_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && response_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
